// ===== src/sfr_pkg.sv =====
// Shared constants, types and codes for the servo frame receiver.
// No dependencies; every other file in the project uses this package.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int HDR_LEN      = 3;
    localparam int TERM_SLOT    = HDR_LEN + NUM_CHANNELS;

    localparam int FILL_W     = $clog2(TERM_SLOT + 1);
    localparam int CHAN_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 16;
    localparam int KIND_W    = 2;
    localparam int CHANNEL_W = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam int PROD_W = BYTE_W + POS_W;

    // Division by 255 is a multiply by ceil(2^31 / 255) and a shift; exact for 24-bit products.
    localparam int            RECIP_W   = 24;
    localparam int            DIV_SHIFT = 31;
    localparam [RECIP_W-1:0]  RECIP_255 = 24'h808081;

    localparam [KIND_W-1:0] KIND_POSITION = 2'd0;
    localparam [KIND_W-1:0] KIND_HEADER   = 2'd1;
    localparam [KIND_W-1:0] KIND_TERM     = 2'd2;

    localparam [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 4'd0;
    localparam [CFG_IDX_W-1:0] REG_HEADER_SECOND = 4'd1;
    localparam [CFG_IDX_W-1:0] REG_HEADER_THIRD  = 4'd2;
    localparam [CFG_IDX_W-1:0] REG_MAX_POSITION  = 4'd3;

    localparam [BYTE_W-1:0] RST_HEADER_FIRST  = 8'h48;
    localparam [BYTE_W-1:0] RST_HEADER_SECOND = 8'h4F;
    localparam [BYTE_W-1:0] RST_HEADER_THIRD  = 8'h50;
    localparam [POS_W-1:0]  RST_MAX_POSITION  = 16'd1023;
    localparam [BYTE_W-1:0] TERMINATOR        = 8'h00;

    typedef struct packed {
        logic              store_byte;
        logic              clear_fill;
        logic              chan_clear;
        logic              chan_inc;
        logic              mult;
        logic              load_pos;
        logic              load_err;
        logic [KIND_W-1:0] err_kind;
    } sfr_cmd_t;

    typedef struct packed {
        logic byte_zero;
        logic at_term;
        logic header_ok;
        logic out_last;
    } sfr_stat_t;

endpackage

`default_nettype wire

// ===== src/sfr_if.sv =====
// Handshake interfaces for the byte input, result output and register write channels.
// Depends on sfr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::KIND_W-1:0]    kind;
    logic [sfr_pkg::CHANNEL_W-1:0] channel;
    logic [sfr_pkg::POS_W-1:0]     position;
    logic                          last;

    modport source (output valid, output kind, output channel, output position,
                    output last, input ready);
    modport sink (input valid, input kind, input channel, input position,
                  input last, output ready);
endinterface

interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] index;
    logic [sfr_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sfr_datapath.sv =====
// Datapath: configuration registers, frame store, fill and channel counters, scaler, result word.
// Depends on sfr_pkg; driven by commands from sfr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire sfr_pkg::sfr_cmd_t           cmd,
    output sfr_pkg::sfr_stat_t               stat,
    input  wire [sfr_pkg::BYTE_W-1:0]        rx_byte,
    input  wire                              cfg_we,
    input  wire [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [sfr_pkg::CFG_DAT_W-1:0]     cfg_data,
    output logic [sfr_pkg::KIND_W-1:0]       kind,
    output logic [sfr_pkg::CHANNEL_W-1:0]    channel,
    output logic [sfr_pkg::POS_W-1:0]        position,
    output logic                             last
);

    logic [sfr_pkg::BYTE_W-1:0]     hdr_first_reg;
    logic [sfr_pkg::BYTE_W-1:0]     hdr_second_reg;
    logic [sfr_pkg::BYTE_W-1:0]     hdr_third_reg;
    logic [sfr_pkg::POS_W-1:0]      max_pos_reg;

    logic [sfr_pkg::BYTE_W-1:0]     hdr_store_reg [sfr_pkg::HDR_LEN];
    logic [sfr_pkg::BYTE_W-1:0]     chan_store [sfr_pkg::NUM_CHANNELS];

    logic [sfr_pkg::FILL_W-1:0]     fill_reg;
    logic [sfr_pkg::FILL_W-1:0]     fill_next;
    logic [sfr_pkg::CHAN_IDX_W-1:0] chan_idx_reg;
    logic [sfr_pkg::CHAN_IDX_W-1:0] chan_idx_next;

    logic [sfr_pkg::PROD_W-1:0]     prod_reg;
    logic [sfr_pkg::PROD_W-1:0]     prod_next;

    logic [sfr_pkg::KIND_W-1:0]     kind_reg;
    logic [sfr_pkg::CHANNEL_W-1:0]  channel_reg;
    logic [sfr_pkg::POS_W-1:0]      position_reg;
    logic                           last_reg;

    logic [sfr_pkg::FILL_W-1:0]     chan_off;
    logic [sfr_pkg::CHAN_IDX_W-1:0] chan_wr_addr;
    logic [sfr_pkg::PROD_W+sfr_pkg::RECIP_W-1:0] recip_prod;
    logic [sfr_pkg::POS_W-1:0]      quotient;
    logic                           chan_is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= sfr_pkg::RST_HEADER_FIRST;
            hdr_second_reg <= sfr_pkg::RST_HEADER_SECOND;
            hdr_third_reg  <= sfr_pkg::RST_HEADER_THIRD;
            max_pos_reg    <= sfr_pkg::RST_MAX_POSITION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfr_pkg::REG_HEADER_FIRST:  hdr_first_reg  <= cfg_data[sfr_pkg::BYTE_W-1:0];
                sfr_pkg::REG_HEADER_SECOND: hdr_second_reg <= cfg_data[sfr_pkg::BYTE_W-1:0];
                sfr_pkg::REG_HEADER_THIRD:  hdr_third_reg  <= cfg_data[sfr_pkg::BYTE_W-1:0];
                sfr_pkg::REG_MAX_POSITION:  max_pos_reg    <= cfg_data[sfr_pkg::POS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign chan_off     = fill_reg - sfr_pkg::FILL_W'(sfr_pkg::HDR_LEN);
    assign chan_wr_addr = chan_off[sfr_pkg::CHAN_IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            if (fill_reg < sfr_pkg::FILL_W'(sfr_pkg::HDR_LEN))
            begin
                hdr_store_reg[fill_reg[1:0]] <= rx_byte;
            end
            else
            begin
                chan_store[chan_wr_addr] <= rx_byte;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
        else if (cmd.store_byte)
        begin
            fill_next = fill_reg + 1'b1;
        end

        chan_idx_next = chan_idx_reg;
        if (cmd.chan_clear)
        begin
            chan_idx_next = '0;
        end
        else if (cmd.chan_inc)
        begin
            chan_idx_next = chan_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            chan_idx_reg <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            chan_idx_reg <= chan_idx_next;
        end
    end

    assign prod_next  = chan_store[chan_idx_reg] * max_pos_reg;
    assign recip_prod = prod_reg * sfr_pkg::RECIP_255;
    assign quotient   = recip_prod[sfr_pkg::DIV_SHIFT+sfr_pkg::POS_W-1:sfr_pkg::DIV_SHIFT];
    assign chan_is_last = (chan_idx_reg == sfr_pkg::CHAN_IDX_W'(sfr_pkg::NUM_CHANNELS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load_pos)
        begin
            kind_reg     <= sfr_pkg::KIND_POSITION;
            channel_reg  <= sfr_pkg::CHANNEL_W'(chan_idx_reg);
            position_reg <= quotient;
            last_reg     <= chan_is_last;
        end
        else if (cmd.load_err)
        begin
            kind_reg     <= cmd.err_kind;
            channel_reg  <= '0;
            position_reg <= '0;
            last_reg     <= 1'b1;
        end
    end

    assign stat.byte_zero = (rx_byte == sfr_pkg::TERMINATOR);
    assign stat.at_term   = (fill_reg == sfr_pkg::FILL_W'(sfr_pkg::TERM_SLOT));
    assign stat.header_ok = (hdr_store_reg[0] == hdr_first_reg)
                          && (hdr_store_reg[1] == hdr_second_reg)
                          && (hdr_store_reg[2] == hdr_third_reg);
    assign stat.out_last  = last_reg;

    assign kind     = kind_reg;
    assign channel  = channel_reg;
    assign position = position_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

// ===== src/sfr_ctrl.sv =====
// Controller state machine: byte intake, resync tracking and the per-channel result sequence.
// Depends on sfr_pkg; commands sfr_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire                     out_ready,
    input  wire sfr_pkg::sfr_stat_t stat,
    output sfr_pkg::sfr_cmd_t       cmd
);

    localparam [1:0] S_IDLE = 2'd0;
    localparam [1:0] S_MUL  = 2'd1;
    localparam [1:0] S_DIV  = 2'd2;
    localparam [1:0] S_SEND = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       resync_reg;
    logic       resync_next;
    logic       in_acc;
    logic       out_acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SEND);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    always_comb
    begin
        state_next  = state_reg;
        resync_next = resync_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (resync_reg)
                    begin
                        if (stat.byte_zero)
                        begin
                            resync_next = 1'b0;
                        end
                    end
                    else if (stat.at_term && !stat.byte_zero)
                    begin
                        cmd.clear_fill = 1'b1;
                        cmd.load_err   = 1'b1;
                        cmd.err_kind   = sfr_pkg::KIND_TERM;
                        resync_next    = 1'b1;
                        state_next     = S_SEND;
                    end
                    else if (stat.at_term)
                    begin
                        cmd.clear_fill = 1'b1;
                        if (stat.header_ok)
                        begin
                            cmd.chan_clear = 1'b1;
                            state_next     = S_MUL;
                        end
                        else
                        begin
                            cmd.load_err = 1'b1;
                            cmd.err_kind = sfr_pkg::KIND_HEADER;
                            state_next   = S_SEND;
                        end
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.load_pos = 1'b1;
                state_next   = S_SEND;
            end
            S_SEND:
            begin
                if (out_acc)
                begin
                    if (stat.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.chan_inc = 1'b1;
                        state_next   = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            resync_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            resync_reg <= resync_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input taken while a result word is pending.");

    a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_DIV))
        else $error("Scaler sequence broken after multiply.");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && stat.out_last) |=> in_ready)
        else $error("Receiver not ready after the final result word.");

    a_resync_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && resync_reg) |=> !out_valid)
        else $error("Result produced while resynchronizing.");
`endif

endmodule

`default_nettype wire

// ===== src/servo_frame_receiver.sv =====
// Servo frame receiver top level: joins the controller and datapath to the channel interfaces.
// Depends on sfr_pkg, sfr_if, sfr_ctrl and sfr_datapath.
// Results: an error word is valid in the cycle after the byte that causes it is taken.
// Each position word passes through the multiply, scale and present states, the first
// after the terminator and each later one after the previous word is taken.
// Throughput: one byte per cycle when no word is produced; input is held while words are sent.
// Reset: asynchronous, active low; clears counters, resync flag, state; sets config defaults.
`timescale 1ns / 1ps
`default_nettype none

module servo_frame_receiver (
    input  wire        clk,
    input  wire        rst_n,
    sfr_in_if.sink     rx,
    sfr_out_if.source  tx,
    sfr_cfg_if.sink    cfg
);

    sfr_pkg::sfr_cmd_t  cmd;
    sfr_pkg::sfr_stat_t stat;

    assign cfg.ready = 1'b1;

    sfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .rx_byte   (rx.rx_byte),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .kind      (tx.kind),
        .channel   (tx.channel),
        .position  (tx.position),
        .last      (tx.last)
    );

endmodule

`default_nettype wire
